@@ sv/qau_pkg.sv @@
// Shared types and constants of the quaternion arithmetic unit.
// No dependencies; every other file of the unit imports this package.
`default_nettype none

package qau_pkg;

    // Default sizes of the Q2.14 number format
    localparam int QAU_FRAC_BITS  = 14;
    localparam int QAU_DATA_WIDTH = 16;

    // Depth of the queue between the front and the back
    localparam int QAU_QDEPTH = 2;

    // Operation codes as carried in req_type
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_SCALE = 3'd3,
        OP_CONJ  = 3'd4,
        OP_NEG   = 3'd5,
        OP_ROT   = 3'd6,
        OP_DOT   = 3'd7
    } op_t;

    // Classification of one item, made by the front, used by the back
    typedef struct packed {
        op_t  op;
        logic lin;    // add, sub, conjugate or negate: no multiplier
        logic ham;    // full Hamilton product
        logic scale;  // a times the scalar b_w
        logic rot;    // vector rotation, two multiplier passes
        logic dot;    // four-component dot product
    } qau_ctrl_t;

endpackage

`default_nettype wire

@@ sv/qau_front.sv @@
// Front of the quaternion unit: accepts items, classifies the operation and
// holds them in a short queue for the back. Depends on qau_pkg.
`default_nettype none

module qau_front import qau_pkg::*; #(
    parameter int DATA_WIDTH = QAU_DATA_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [2:0]                in_req_type,
    input  wire logic [4*DATA_WIDTH-1:0]   in_a,
    input  wire logic [4*DATA_WIDTH-1:0]   in_b,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output qau_ctrl_t                      out_ctrl,
    output logic [4*DATA_WIDTH-1:0]        out_a,
    output logic [4*DATA_WIDTH-1:0]        out_b
);

    localparam int PTR_W = (QAU_QDEPTH > 1) ? $clog2(QAU_QDEPTH) : 1;
    localparam int CNT_W = $clog2(QAU_QDEPTH + 1);

    qau_ctrl_t                 ctrl_q   [QAU_QDEPTH];
    logic [4*DATA_WIDTH-1:0]   a_q      [QAU_QDEPTH];
    logic [4*DATA_WIDTH-1:0]   b_q      [QAU_QDEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    qau_ctrl_t                 dec_ctrl;
    logic                      push;
    logic                      pop;

    // Classify the operation code
    always_comb begin
        dec_ctrl       = '0;
        dec_ctrl.op    = op_t'(in_req_type);
        case (op_t'(in_req_type))
            OP_ADD, OP_SUB, OP_CONJ, OP_NEG: dec_ctrl.lin = 1'b1;
            OP_MUL:   dec_ctrl.ham   = 1'b1;
            OP_SCALE: dec_ctrl.scale = 1'b1;
            OP_ROT:   dec_ctrl.rot   = 1'b1;
            OP_DOT:   dec_ctrl.dot   = 1'b1;
            default:  dec_ctrl.lin   = 1'b0;
        endcase
    end

    // Queue handshake
    assign in_ready  = (count_reg != CNT_W'(QAU_QDEPTH));
    assign push      = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    assign out_ctrl = ctrl_q[rd_ptr_reg];
    assign out_a    = a_q[rd_ptr_reg];
    assign out_b    = b_q[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QAU_QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QAU_QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the item in its slot
    always_ff @(posedge aclk) begin
        if (push) begin
            ctrl_q[wr_ptr_reg] <= dec_ctrl;
            a_q[wr_ptr_reg]    <= in_a;
            b_q[wr_ptr_reg]    <= in_b;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QAU_QDEPTH))
        else $error("queue count beyond depth");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 && push) |=> out_valid)
        else $error("item pushed into empty queue not offered");
`endif

endmodule

`default_nettype wire

@@ sv/qau_back.sv @@
// Back of the quaternion unit: four-stage pipeline with two multiplier banks,
// sums, saturation and the output register. Depends on qau_pkg.
`default_nettype none

module qau_back import qau_pkg::*; #(
    parameter int FRAC_BITS  = QAU_FRAC_BITS,
    parameter int DATA_WIDTH = QAU_DATA_WIDTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire qau_ctrl_t                 in_ctrl,
    input  wire logic [4*DATA_WIDTH-1:0]   in_a,
    input  wire logic [4*DATA_WIDTH-1:0]   in_b,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [DATA_WIDTH-1:0]   out_r_w,
    output logic signed [DATA_WIDTH-1:0]   out_r_x,
    output logic signed [DATA_WIDTH-1:0]   out_r_y,
    output logic signed [DATA_WIDTH-1:0]   out_r_z,
    output logic signed [DATA_WIDTH-1:0]   out_dot_value,
    output logic                           out_overflow
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW + 1;   // one shifted product
    localparam int SW = PW + 2;       // sum of four products

    localparam logic signed [SW-1:0] MAXV = {{(SW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

    function automatic logic signed [SW-1:0] ext_p(input logic signed [PW-1:0] v);
        return $signed({{(SW - PW){v[PW-1]}}, v});
    endfunction

    // Saturate to DW bits; the top bit of the result flags a clip
    function automatic logic [DW:0] sat_f(input logic signed [SW-1:0] v);
        logic [DW:0] res;
        if (v > MAXV) begin
            res = {1'b1, MAXV[DW-1:0]};
        end else if (v < MINV) begin
            res = {1'b1, MINV[DW-1:0]};
        end else begin
            res = {1'b0, v[DW-1:0]};
        end
        return res;
    endfunction

    // Operands of the incoming item
    logic signed [DW-1:0] a_s [4];
    logic signed [DW-1:0] b_s [4];
    logic signed [DW-1:0] m_s [4];

    // Stage 1: first products and linear results
    logic                 v1_reg;
    qau_ctrl_t            c1_reg;
    logic signed [PW-1:0] sp1_reg  [4][4];
    logic signed [PW-1:0] sp1_next [4][4];
    logic signed [DW:0]   lin1_reg [4];
    logic signed [DW:0]   lin1_next[4];
    logic signed [DW-1:0] a1_reg   [4];

    // Stage 2: first sums, rotation intermediate
    logic                 v2_reg;
    qau_ctrl_t            c2_reg;
    logic signed [SW-1:0] h    [4];
    logic signed [SW-1:0] dsum;
    logic [DW:0]          tsat [4];
    logic signed [SW-1:0] q2_reg  [4];
    logic signed [SW-1:0] q2_next [4];
    logic signed [SW-1:0] d2_reg, d2_next;
    logic signed [DW-1:0] t2_reg  [4];
    logic                 ov2_reg, ov2_next;
    logic signed [DW-1:0] a2_reg  [4];

    // Stage 3: second products for rotation
    logic                 v3_reg;
    qau_ctrl_t            c3_reg;
    logic signed [DW:0]   cj   [4];
    logic signed [PW-1:0] sp3_reg  [4][4];
    logic signed [PW-1:0] sp3_next [4][4];
    logic signed [SW-1:0] q3_reg  [4];
    logic signed [SW-1:0] d3_reg;
    logic                 ov3_reg;

    // Stage 4: output register
    logic                 v4_reg;
    qau_ctrl_t            c4_reg;
    logic signed [SW-1:0] g    [4];
    logic signed [SW-1:0] fin  [4];
    logic [DW:0]          rsat [4];
    logic [DW:0]          dsat;
    logic signed [DW-1:0] r4_reg  [4];
    logic signed [DW-1:0] r4_next [4];
    logic signed [DW-1:0] dv4_reg, dv4_next;
    logic                 ov4_reg, ov4_next;

    logic rdy1, rdy2, rdy3, rdy4;

    // Stage ready chain: a stage moves when empty or when its successor moves
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Unpack operands; rotation treats b as a pure vector
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a_s[i] = $signed(in_a[i*DW +: DW]);
            b_s[i] = $signed(in_b[i*DW +: DW]);
            m_s[i] = (in_ctrl.rot && i == 0) ? '0 : b_s[i];
        end
    end

    // First product bank and linear operations
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                sp1_next[i][j] = (PW'(a_s[i]) * PW'(m_s[j])) >>> FRAC_BITS;
            end
            case (in_ctrl.op)
                OP_ADD:  lin1_next[i] = (DW+1)'(a_s[i]) + (DW+1)'(b_s[i]);
                OP_SUB:  lin1_next[i] = (DW+1)'(a_s[i]) - (DW+1)'(b_s[i]);
                OP_CONJ: lin1_next[i] = (i == 0) ? (DW+1)'(a_s[i]) : -(DW+1)'(a_s[i]);
                OP_NEG:  lin1_next[i] = -(DW+1)'(a_s[i]);
                default: lin1_next[i] = '0;
            endcase
        end
    end

    // First Hamilton sums, scale and dot; linear results pass through
    always_comb begin
        h[0] = ext_p(sp1_reg[0][0]) - ext_p(sp1_reg[1][1])
             - ext_p(sp1_reg[2][2]) - ext_p(sp1_reg[3][3]);
        h[1] = ext_p(sp1_reg[0][1]) + ext_p(sp1_reg[1][0])
             + ext_p(sp1_reg[2][3]) - ext_p(sp1_reg[3][2]);
        h[2] = ext_p(sp1_reg[0][2]) - ext_p(sp1_reg[1][3])
             + ext_p(sp1_reg[2][0]) + ext_p(sp1_reg[3][1]);
        h[3] = ext_p(sp1_reg[0][3]) + ext_p(sp1_reg[1][2])
             - ext_p(sp1_reg[2][1]) + ext_p(sp1_reg[3][0]);
        dsum = ext_p(sp1_reg[0][0]) + ext_p(sp1_reg[1][1])
             + ext_p(sp1_reg[2][2]) + ext_p(sp1_reg[3][3]);
        ov2_next = 1'b0;
        for (int i = 0; i < 4; i++) begin
            tsat[i] = sat_f(h[i]);
            if (c1_reg.rot && tsat[i][DW]) begin
                ov2_next = 1'b1;
            end
            if (c1_reg.ham) begin
                q2_next[i] = h[i];
            end else if (c1_reg.scale) begin
                q2_next[i] = ext_p(sp1_reg[i][0]);
            end else if (c1_reg.lin) begin
                q2_next[i] = SW'(lin1_reg[i]);
            end else begin
                q2_next[i] = '0;
            end
        end
        d2_next = c1_reg.dot ? dsum : '0;
    end

    // Second product bank: clipped intermediate times conjugate of a
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            cj[j] = (j == 0) ? (DW+1)'(a2_reg[j]) : -(DW+1)'(a2_reg[j]);
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                sp3_next[i][j] = (PW'(t2_reg[i]) * PW'(cj[j])) >>> FRAC_BITS;
            end
        end
    end

    // Final sums and saturation; the real part of a rotation is dropped
    always_comb begin
        g[0] = '0;
        g[1] = ext_p(sp3_reg[0][1]) + ext_p(sp3_reg[1][0])
             + ext_p(sp3_reg[2][3]) - ext_p(sp3_reg[3][2]);
        g[2] = ext_p(sp3_reg[0][2]) - ext_p(sp3_reg[1][3])
             + ext_p(sp3_reg[2][0]) + ext_p(sp3_reg[3][1]);
        g[3] = ext_p(sp3_reg[0][3]) + ext_p(sp3_reg[1][2])
             - ext_p(sp3_reg[2][1]) + ext_p(sp3_reg[3][0]);
        ov4_next = ov3_reg;
        for (int i = 0; i < 4; i++) begin
            fin[i]     = c3_reg.rot ? g[i] : q3_reg[i];
            rsat[i]    = sat_f(fin[i]);
            r4_next[i] = $signed(rsat[i][DW-1:0]);
            if (rsat[i][DW]) begin
                ov4_next = 1'b1;
            end
        end
        dsat     = sat_f(d3_reg);
        dv4_next = $signed(dsat[DW-1:0]);
        if (dsat[DW]) begin
            ov4_next = 1'b1;
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            c1_reg   <= in_ctrl;
            sp1_reg  <= sp1_next;
            lin1_reg <= lin1_next;
            a1_reg   <= a_s;
        end
        if (rdy2 && v1_reg) begin
            c2_reg  <= c1_reg;
            q2_reg  <= q2_next;
            d2_reg  <= d2_next;
            ov2_reg <= ov2_next;
            a2_reg  <= a1_reg;
            for (int i = 0; i < 4; i++) begin
                t2_reg[i] <= $signed(tsat[i][DW-1:0]);
            end
        end
        if (rdy3 && v2_reg) begin
            c3_reg  <= c2_reg;
            sp3_reg <= sp3_next;
            q3_reg  <= q2_reg;
            d3_reg  <= d2_reg;
            ov3_reg <= ov2_reg;
        end
        if (rdy4 && v3_reg) begin
            c4_reg  <= c3_reg;
            r4_reg  <= r4_next;
            dv4_reg <= dv4_next;
            ov4_reg <= ov4_next;
        end
    end

    assign out_valid     = v4_reg;
    assign out_r_w       = r4_reg[0];
    assign out_r_x       = r4_reg[1];
    assign out_r_y       = r4_reg[2];
    assign out_r_z       = r4_reg[3];
    assign out_dot_value = dv4_reg;
    assign out_overflow  = ov4_reg;

`ifndef SYNTHESIS
    a_dot_zero_quat: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && c4_reg.dot) |->
        (r4_reg[0] == '0 && r4_reg[1] == '0 && r4_reg[2] == '0 && r4_reg[3] == '0))
        else $error("dot item with non-zero quaternion result");

    a_rot_real_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && c4_reg.rot) |-> (r4_reg[0] == '0))
        else $error("rotation item with non-zero real part");

    a_dot_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !c4_reg.dot) |-> (dv4_reg == '0))
        else $error("dot value set on a non-dot item");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy3) |=> v3_reg)
        else $error("stalled item dropped from rotation stage");
`endif

endmodule

`default_nettype wire

@@ sv/quaternion_arithmetic_unit.sv @@
// Quaternion arithmetic unit: a front that accepts and classifies items, a
// two-item queue, and a four-stage back pipeline. Depends on qau_pkg.
//
// Unstalled, the unit takes one item per cycle and returns one result per item
// in order: add, subtract, Hamilton product, scale, conjugate, negate, rotate
// and dot on signed fixed point with FRAC_BITS fraction bits. Each product is
// shifted right arithmetically on its own, and every component saturates,
// setting overflow. An accepted item passes the queue, two multiplier stages
// (the second used by rotation) each followed by a sum stage, the last ending
// in the output register. The 32 multipliers of the two product banks hold
// the rate of one item per cycle; with the queue and output register either
// side may stall without idling the other.
`default_nettype none

module quaternion_arithmetic_unit import qau_pkg::*; #(
    parameter int FRAC_BITS  = QAU_FRAC_BITS,
    parameter int DATA_WIDTH = QAU_DATA_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [2:0]                    s_req_type,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_w,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_x,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_y,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_z,
    input  wire logic signed [DATA_WIDTH-1:0]  s_b_w,
    input  wire logic signed [DATA_WIDTH-1:0]  s_b_x,
    input  wire logic signed [DATA_WIDTH-1:0]  s_b_y,
    input  wire logic signed [DATA_WIDTH-1:0]  s_b_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_r_w,
    output logic signed [DATA_WIDTH-1:0]       m_r_x,
    output logic signed [DATA_WIDTH-1:0]       m_r_y,
    output logic signed [DATA_WIDTH-1:0]       m_r_z,
    output logic signed [DATA_WIDTH-1:0]       m_dot_value,
    output logic                               m_overflow
);

    logic                        q_valid;
    logic                        q_ready;
    qau_ctrl_t                   q_ctrl;
    logic [4*DATA_WIDTH-1:0]     q_a;
    logic [4*DATA_WIDTH-1:0]     q_b;

    // Accept, classify and queue
    qau_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_req_type (s_req_type),
        .in_a        ({s_a_z, s_a_y, s_a_x, s_a_w}),
        .in_b        ({s_b_z, s_b_y, s_b_x, s_b_w}),
        .out_valid   (q_valid),
        .out_ready   (q_ready),
        .out_ctrl    (q_ctrl),
        .out_a       (q_a),
        .out_b       (q_b)
    );

    // Compute and drive results
    qau_back #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_ctrl       (q_ctrl),
        .in_a          (q_a),
        .in_b          (q_b),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_r_w       (m_r_w),
        .out_r_x       (m_r_x),
        .out_r_y       (m_r_y),
        .out_r_z       (m_r_z),
        .out_dot_value (m_dot_value),
        .out_overflow  (m_overflow)
    );

endmodule

`default_nettype wire

@@ tb/sv/quaternion_arithmetic_unit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the quaternion arithmetic unit: predicts each result from the accepted item.
// It watches both channels and compares in order. Depends on qau_pkg for op_t and the sizes.

module quaternion_arithmetic_unit_checker import qau_pkg::*; #(
    parameter int DW = QAU_DATA_WIDTH,
    parameter int FB = QAU_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [2:0]           s_req_type,
    input  logic signed [DW-1:0] s_a_w,
    input  logic signed [DW-1:0] s_a_x,
    input  logic signed [DW-1:0] s_a_y,
    input  logic signed [DW-1:0] s_a_z,
    input  logic signed [DW-1:0] s_b_w,
    input  logic signed [DW-1:0] s_b_x,
    input  logic signed [DW-1:0] s_b_y,
    input  logic signed [DW-1:0] s_b_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [DW-1:0] m_r_w,
    input  logic signed [DW-1:0] m_r_x,
    input  logic signed [DW-1:0] m_r_y,
    input  logic signed [DW-1:0] m_r_z,
    input  logic signed [DW-1:0] m_dot_value,
    input  logic                 m_overflow,
    output int                   mismatches,
    output int                   outstanding,
    output int                   results_seen,
    output int                   saturated_seen
);

    localparam longint SAT_MAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    typedef struct {
        longint w, x, y, z;
    } quat_wide_t;

    typedef struct packed {
        logic signed [DW-1:0] r_w;
        logic signed [DW-1:0] r_x;
        logic signed [DW-1:0] r_y;
        logic signed [DW-1:0] r_z;
        logic signed [DW-1:0] dot_value;
        logic                 overflow;
    } quat_result_t;

    quat_result_t expected_results[$];
    int           err_count;
    int           got_count;
    int           sat_count;

    // Product of two components, floored by the fraction bits
    function automatic longint fx_mul(input longint p, input longint q);
        return (p * q) >>> FB;
    endfunction

    function automatic longint clamp(input longint v, inout bit ovf);
        if (v > SAT_MAX) begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        if (v < SAT_MIN) begin
            ovf = 1'b1;
            return SAT_MIN;
        end
        return v;
    endfunction

    function automatic quat_wide_t clamp_quat(input quat_wide_t q, inout bit ovf);
        quat_wide_t r;
        r.w = clamp(q.w, ovf);
        r.x = clamp(q.x, ovf);
        r.y = clamp(q.y, ovf);
        r.z = clamp(q.z, ovf);
        return r;
    endfunction

    function automatic quat_wide_t hamilton(input quat_wide_t p, input quat_wide_t q);
        quat_wide_t r;
        r.w = fx_mul(p.w, q.w) - fx_mul(p.x, q.x) - fx_mul(p.y, q.y) - fx_mul(p.z, q.z);
        r.x = fx_mul(p.w, q.x) + fx_mul(p.x, q.w) + fx_mul(p.y, q.z) - fx_mul(p.z, q.y);
        r.y = fx_mul(p.w, q.y) - fx_mul(p.x, q.z) + fx_mul(p.y, q.w) + fx_mul(p.z, q.x);
        r.z = fx_mul(p.w, q.z) + fx_mul(p.x, q.y) - fx_mul(p.y, q.x) + fx_mul(p.z, q.w);
        return r;
    endfunction

    function automatic quat_result_t predict_result(input op_t op, input quat_wide_t a,
                                                    input quat_wide_t b);
        quat_wide_t   r;
        quat_wide_t   t;
        quat_wide_t   c;
        longint       dot_sum;
        bit           ovf;
        quat_result_t res;
        r       = '{0, 0, 0, 0};
        dot_sum = 0;
        ovf     = 1'b0;
        case (op)
            OP_ADD: begin
                r = '{a.w + b.w, a.x + b.x, a.y + b.y, a.z + b.z};
            end
            OP_SUB: begin
                r = '{a.w - b.w, a.x - b.x, a.y - b.y, a.z - b.z};
            end
            OP_MUL: begin
                r = hamilton(a, b);
            end
            OP_SCALE: begin
                r = '{fx_mul(a.w, b.w), fx_mul(a.x, b.w), fx_mul(a.y, b.w), fx_mul(a.z, b.w)};
            end
            OP_CONJ: begin
                r = '{a.w, -a.x, -a.y, -a.z};
            end
            OP_NEG: begin
                r = '{-a.w, -a.x, -a.y, -a.z};
            end
            OP_ROT: begin
                // a*v saturates on its own before the product with conj(a)
                b.w = 0;
                t   = clamp_quat(hamilton(a, b), ovf);
                c   = '{a.w, -a.x, -a.y, -a.z};
                r   = hamilton(t, c);
                r.w = 0;
            end
            OP_DOT: begin
                dot_sum = clamp(fx_mul(a.w, b.w) + fx_mul(a.x, b.x)
                              + fx_mul(a.y, b.y) + fx_mul(a.z, b.z), ovf);
            end
            default: ;
        endcase
        r             = clamp_quat(r, ovf);
        res.r_w       = DW'(r.w);
        res.r_x       = DW'(r.x);
        res.r_y       = DW'(r.y);
        res.r_z       = DW'(r.z);
        res.dot_value = DW'(dot_sum);
        res.overflow  = ovf;
        return res;
    endfunction

    // Predict on each accepted item, compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        quat_result_t exp_r;
        quat_result_t got_r;
        bit           bad;
        if (!aresetn) begin
            expected_results.delete();
            err_count = 0;
            got_count = 0;
            sat_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got_r = '{m_r_w, m_r_x, m_r_y, m_r_z, m_dot_value, m_overflow};
                got_count++;
                if (got_r.overflow === 1'b1) sat_count++;
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result %0d arrived with no item outstanding",
                                 $realtime, got_count);
                end else begin
                    exp_r = expected_results.pop_front();
                    bad   = (got_r.r_w !== exp_r.r_w) || (got_r.r_x !== exp_r.r_x)
                         || (got_r.r_y !== exp_r.r_y) || (got_r.r_z !== exp_r.r_z)
                         || (got_r.dot_value !== exp_r.dot_value)
                         || (got_r.overflow !== exp_r.overflow);
                    if (bad) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("%0t: result %0d mismatch", $realtime, got_count);
                            $display("  expected w=%0d x=%0d y=%0d z=%0d dot=%0d ovf=%b",
                                     exp_r.r_w, exp_r.r_x, exp_r.r_y, exp_r.r_z,
                                     exp_r.dot_value, exp_r.overflow);
                            $display("  actual   w=%0d x=%0d y=%0d z=%0d dot=%0d ovf=%b",
                                     got_r.r_w, got_r.r_x, got_r.r_y, got_r.r_z,
                                     got_r.dot_value, got_r.overflow);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(op_t'(s_req_type),
                    '{s_a_w, s_a_x, s_a_y, s_a_z}, '{s_b_w, s_b_x, s_b_y, s_b_z}));
            end
        end
        mismatches     <= err_count;
        outstanding    <= expected_results.size();
        results_seen   <= got_count;
        saturated_seen <= sat_count;
    end

endmodule

@@ tb/sv/quaternion_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the quaternion arithmetic unit testbench: clock, reset, item stimulus and verdict.
// Depends on qau_pkg, the unit itself and quaternion_arithmetic_unit_checker.

module quaternion_arithmetic_unit_tb;
    import qau_pkg::*;

    localparam int DW          = QAU_DATA_WIDTH;
    localparam int FB          = QAU_FRAC_BITS;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 120;
    localparam int DRAIN_AT    = 800;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [DW-1:0] comp_t;

    localparam comp_t Q_MAX  = {1'b0, {(DW - 1){1'b1}}};
    localparam comp_t Q_MIN  = {1'b1, {(DW - 1){1'b0}}};
    localparam comp_t Q_ONE  = comp_t'(1 <<< FB);
    localparam comp_t Q_MONE = comp_t'(-(1 <<< FB));
    localparam comp_t Q_HALF_SQRT2 = comp_t'(11585);

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    logic  [2:0] s_req_type;
    comp_t s_a_w, s_a_x, s_a_y, s_a_z;
    comp_t s_b_w, s_b_x, s_b_y, s_b_z;
    logic  m_valid;
    logic  m_ready;
    comp_t m_r_w, m_r_x, m_r_y, m_r_z, m_dot_value;
    logic  m_overflow;

    int mismatches;
    int outstanding;
    int results_seen;
    int saturated_seen;
    int sent_count  = 0;
    int burst_left  = 0;
    int hold_cycles = 0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    quaternion_arithmetic_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_a_w      (s_a_w),
        .s_a_x      (s_a_x),
        .s_a_y      (s_a_y),
        .s_a_z      (s_a_z),
        .s_b_w      (s_b_w),
        .s_b_x      (s_b_x),
        .s_b_y      (s_b_y),
        .s_b_z      (s_b_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_r_w      (m_r_w),
        .m_r_x      (m_r_x),
        .m_r_y      (m_r_y),
        .m_r_z      (m_r_z),
        .m_dot_value(m_dot_value),
        .m_overflow (m_overflow)
    );

    quaternion_arithmetic_unit_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_a_w         (s_a_w),
        .s_a_x         (s_a_x),
        .s_a_y         (s_a_y),
        .s_a_z         (s_a_z),
        .s_b_w         (s_b_w),
        .s_b_x         (s_b_x),
        .s_b_y         (s_b_y),
        .s_b_z         (s_b_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_r_w         (m_r_w),
        .m_r_x         (m_r_x),
        .m_r_y         (m_r_y),
        .m_r_z         (m_r_z),
        .m_dot_value   (m_dot_value),
        .m_overflow    (m_overflow),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .saturated_seen(saturated_seen)
    );

    // Component mix: full range, near unit magnitude, or an extreme value
    function automatic comp_t pick_component();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return comp_t'($urandom_range(0, 65535));
        if (sel < 8) return comp_t'(int'($urandom_range(0, 2 * (1 << FB))) - (1 << FB));
        case ($urandom_range(0, 5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return comp_t'(-1);
            3:       return Q_ONE;
            4:       return Q_MONE;
            default: return comp_t'(0);
        endcase
    endfunction

    // Offer one item, hold it until accepted, then pace the next burst
    task automatic send_item(input op_t op, input comp_t aw, input comp_t ax, input comp_t ay,
                             input comp_t az, input comp_t bw, input comp_t bx,
                             input comp_t by, input comp_t bz);
        int gap;
        bit in_pressure;
        s_valid    <= 1'b1;
        s_req_type <= op;
        s_a_w <= aw; s_a_x <= ax; s_a_y <= ay; s_a_z <= az;
        s_b_w <= bw; s_b_x <= bx; s_b_y <= by; s_b_z <= bz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        if (burst_left > 0) burst_left--;
        in_pressure = (sent_count >= HOLD_AT) && (sent_count < HOLD_AT + 150);
        if (burst_left == 0 && !in_pressure) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Stop offering and wait until every outstanding item has returned
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Receiver: change stall pattern now and then, with one long hold-off
    initial begin : receiver
        int mode;
        int span;
        int tick;
        bit held;
        m_ready <= 1'b0;
        held = 1'b0;
        tick = 0;
        wait (aresetn === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                if (!held && sent_count >= HOLD_AT) begin
                    held = 1'b1;
                    m_ready <= 1'b0;
                    while (hold_cycles < HOLD_LEN) begin
                        @(posedge aclk);
                        hold_cycles++;
                    end
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d items outstanding", cycle_count, outstanding);
        $display("FAIL quaternion_arithmetic_unit");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        op_t op;
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_req_type <= OP_ADD;
        s_a_w <= '0; s_a_x <= '0; s_a_y <= '0; s_a_z <= '0;
        s_b_w <= '0; s_b_x <= '0; s_b_y <= '0; s_b_z <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of every operation and the saturating corners
        send_item(OP_ADD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(OP_ADD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_item(OP_ADD, '0, '0, '0, '0, '0, '0, '0, '0);
        send_item(OP_SUB, Q_MAX, Q_MIN, '0, Q_ONE, Q_MIN, Q_MAX, '0, Q_MONE);
        send_item(OP_SUB, Q_MIN, Q_MAX, comp_t'(-1), '0, Q_MAX, Q_MIN, comp_t'(1), '0);
        send_item(OP_MUL, Q_ONE, '0, '0, '0, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_item(OP_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        // a product of minus one and one floors to minus one
        send_item(OP_MUL, comp_t'(-1), comp_t'(-1), comp_t'(-1), comp_t'(-1),
                  comp_t'(1), comp_t'(1), comp_t'(1), comp_t'(1));
        send_item(OP_SCALE, Q_MAX, Q_MIN, Q_ONE, comp_t'(-1), Q_MIN, '0, '0, '0);
        send_item(OP_SCALE, Q_MAX, Q_MIN, Q_ONE, comp_t'(-1), Q_ONE, Q_MAX, Q_MIN, '0);
        send_item(OP_SCALE, comp_t'(-1), comp_t'(1), Q_MONE, Q_MAX, comp_t'(1), '0, '0, '0);
        // negating the most negative value saturates
        send_item(OP_CONJ, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(OP_CONJ, Q_ONE, Q_MAX, comp_t'(-5), '0, '0, '0, '0, '0);
        send_item(OP_NEG, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0);
        send_item(OP_NEG, Q_MAX, comp_t'(-1), '0, Q_ONE, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_item(OP_ROT, Q_ONE, '0, '0, '0, Q_MAX, Q_ONE, Q_MONE, Q_MIN);
        send_item(OP_ROT, Q_HALF_SQRT2, '0, '0, Q_HALF_SQRT2, '0, Q_ONE, '0, '0);
        // rotation whose intermediate product saturates
        send_item(OP_ROT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(OP_ROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_item(OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(OP_DOT, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_item(OP_DOT, Q_ONE, Q_MONE, comp_t'(-1), '0, Q_ONE, Q_ONE, comp_t'(1), Q_MIN);
        wait_drained();

        // Random items over every operation
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (sent_count == DRAIN_AT) wait_drained();
            op = op_t'($urandom_range(0, 7));
            send_item(op, pick_component(), pick_component(), pick_component(),
                      pick_component(), pick_component(), pick_component(),
                      pick_component(), pick_component());
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Sent %0d items over all eight operations; %0d results checked, %0d saturated.",
                 sent_count, results_seen, saturated_seen);
        $display("Receiver held off for %0d cycles once; %0d mismatches.",
                 hold_cycles, mismatches);
        if (mismatches == 0) begin
            $display("PASS quaternion_arithmetic_unit");
        end else begin
            $display("FAIL quaternion_arithmetic_unit");
        end
        $finish;
    end

endmodule
